// File: sv/klt_pkg.sv
// Shared types and constants for the key/location table.
// No dependencies; every other file imports this package.
package klt_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_WIDTH = 16;
  localparam int LOC_WIDTH = 32;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic shift;   // remove step: cells at or above the lowest hit take the upper neighbor
    logic add;     // append at the tail cell
    logic upd;     // rewrite the location of the first hit
  } cell_cmd_t;

  // Per-cell position info derived from the count.
  typedef struct packed {
    logic occ;     // index below count
    logic tail;    // index equals count
  } cell_pos_t;

  typedef struct packed {
    logic                 found;
    logic [LOC_WIDTH-1:0] loc_out;
    logic [CNT_W-1:0]     entry_count;
    logic                 overflow;
  } result_t;

endpackage

// File: sv/klt_if.sv
// Handshake channels for the key/location table: request and result.
// Depends on klt_pkg for field widths.
interface klt_req_if import klt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [KEY_WIDTH-1:0] key;
  logic [LOC_WIDTH-1:0] loc_in;

  modport source (output valid, mode, key, loc_in, input ready);
  modport sink   (input valid, mode, key, loc_in, output ready);
endinterface

interface klt_rsp_if import klt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [LOC_WIDTH-1:0] loc_out;
  logic [CNT_W-1:0]     entry_count;
  logic                 overflow;

  modport source (output valid, found, loc_out, entry_count, overflow, input ready);
  modport sink   (input valid, found, loc_out, entry_count, overflow, output ready);
endinterface

// File: sv/klt_cell.sv
// One table entry: key and location, equality compare, and the links of
// the hit / first-location chain. Depends on klt_pkg.
module klt_cell import klt_pkg::*; (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  cell_pos_t            pos,
  input  logic [KEY_WIDTH-1:0] key_req,
  input  logic [LOC_WIDTH-1:0] loc_req,
  input  logic [KEY_WIDTH-1:0] key_up,
  input  logic [LOC_WIDTH-1:0] loc_up,
  input  logic                 hit_in,
  input  logic [LOC_WIDTH-1:0] first_loc_in,
  output logic [KEY_WIDTH-1:0] key_q,
  output logic [LOC_WIDTH-1:0] loc_q,
  output logic                 hit_out,
  output logic [LOC_WIDTH-1:0] first_loc_out
);

  logic match;
  logic first;

  assign match         = pos.occ && (key_q == key_req);
  assign first         = match && !hit_in;
  assign hit_out       = hit_in || match;
  assign first_loc_out = first ? loc_q : first_loc_in;

  always_ff @(posedge clk) begin
    if (cmd.shift && hit_out) begin
      key_q <= key_up;
      loc_q <= loc_up;
    end else if (cmd.add && pos.tail) begin
      key_q <= key_req;
      loc_q <= loc_req;
    end else if (cmd.upd && first) begin
      loc_q <= loc_req;
    end
  end

endmodule

// File: sv/klt_ctrl.sv
// Request sequencer for the key/location table: request registers, entry
// count, remove loop and the result register. Depends on klt_pkg.
module klt_ctrl import klt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [LOC_WIDTH-1:0] in_loc,
  input  logic                 any_hit,
  input  logic [LOC_WIDTH-1:0] first_loc,
  output cell_cmd_t            cmd,
  output logic [KEY_WIDTH-1:0] key_req,
  output logic [LOC_WIDTH-1:0] loc_req,
  output logic [CNT_W-1:0]     count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              result
);

  state_t           state, state_next;
  mode_t            mode_req;
  logic             rm_hit;
  logic [CNT_W-1:0] count_next;
  logic             out_free;
  logic             full;
  logic             done;
  result_t          result_next;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign full     = (count == CNT_W'(ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    done        = 1'b0;
    count_next  = count;
    result_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (mode_req == MODE_REMOVE && any_hit) begin
          // drop the lowest hit this cycle, re-compare next cycle
          cmd.shift  = 1'b1;
          count_next = count - CNT_W'(1);
        end else if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
          unique case (mode_req)
            MODE_ADD: begin
              cmd.add              = !full;
              result_next.found    = !full;
              result_next.overflow = full;
              if (!full) count_next = count + CNT_W'(1);
            end
            MODE_REMOVE: result_next.found = rm_hit;
            MODE_LOOKUP: begin
              result_next.found   = any_hit;
              result_next.loc_out = first_loc;
            end
            MODE_UPDATE: begin
              cmd.upd           = 1'b1;
              result_next.found = any_hit;
            end
            default: ;
          endcase
          result_next.entry_count = count_next;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      rm_hit    <= 1'b0;
    end else begin
      count <= count_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        rm_hit <= 1'b0;
      end else if (cmd.shift) begin
        rm_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_req <= mode_t'(in_mode);
      key_req  <= in_key;
      loc_req  <= in_loc;
    end
    if (done) begin
      result <= result_next;
    end
  end

endmodule

// File: sv/key_location_table.sv
// Top level of the key/location table: controller plus a row of entry cells.
// Depends on klt_pkg, klt_if, klt_cell and klt_ctrl.
//
//   channel | dir | fields
//   --------+-----+-----------------------------------------
//   req     | in  | mode[1:0], key[15:0], loc_in[31:0]
//   rsp     | out | found, loc_out[31:0], entry_count[4:0], overflow
//
// Add, lookup and update: accept, then one compare/write step across all cells,
// made once the result register is free. Remove repeats a shift step while any
// cell matches; each shifts the cells above the lowest match down by one.
// Reset clears the count and the result valid; entry contents are not cleared.
// A new request is taken while a result waits; it completes once rsp drains.
module key_location_table import klt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  klt_req_if.sink      req,
  klt_rsp_if.source    rsp
);

  cell_cmd_t            cmd;
  logic [KEY_WIDTH-1:0] key_req;
  logic [LOC_WIDTH-1:0] loc_req;
  logic [CNT_W-1:0]     count;
  result_t              result;

  logic [KEY_WIDTH-1:0] key_q   [ENTRIES];
  logic [LOC_WIDTH-1:0] loc_q   [ENTRIES];
  logic [ENTRIES:0]     hit_ch;
  logic [LOC_WIDTH-1:0] loc_ch  [ENTRIES+1];

  assign hit_ch[0] = 1'b0;
  assign loc_ch[0] = '0;

  klt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_mode   (req.mode),
    .in_key    (req.key),
    .in_loc    (req.loc_in),
    .any_hit   (hit_ch[ENTRIES]),
    .first_loc (loc_ch[ENTRIES]),
    .cmd       (cmd),
    .key_req   (key_req),
    .loc_req   (loc_req),
    .count     (count),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .result    (result)
  );

  assign rsp.found       = result.found;
  assign rsp.loc_out     = result.loc_out;
  assign rsp.entry_count = result.entry_count;
  assign rsp.overflow    = result.overflow;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_pos_t            pos;
    logic [KEY_WIDTH-1:0] key_up;
    logic [LOC_WIDTH-1:0] loc_up;

    assign pos.occ  = (CNT_W'(i) < count);
    assign pos.tail = (CNT_W'(i) == count);

    // top cell has no upper neighbor; what it takes lies above the count
    if (i == ENTRIES - 1) begin : g_top
      assign key_up = key_q[i];
      assign loc_up = loc_q[i];
    end else begin : g_mid
      assign key_up = key_q[i+1];
      assign loc_up = loc_q[i+1];
    end

    klt_cell u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .pos           (pos),
      .key_req       (key_req),
      .loc_req       (loc_req),
      .key_up        (key_up),
      .loc_up        (loc_up),
      .hit_in        (hit_ch[i]),
      .first_loc_in  (loc_ch[i]),
      .key_q         (key_q[i]),
      .loc_q         (loc_q[i]),
      .hit_out       (hit_ch[i+1]),
      .first_loc_out (loc_ch[i+1])
    );
  end

endmodule

// File: sv/klt_checker.sv
// Port-level checks on the key/location table result channel, and the bind
// that attaches them to key_location_table. Depends on klt_pkg.
module klt_checker import klt_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic                 found,
  input logic [LOC_WIDTH-1:0] loc_out,
  input logic [CNT_W-1:0]     entry_count,
  input logic                 overflow
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_count <= CNT_W'(ENTRIES))
    else $error("entry_count above table size");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && overflow |-> !found && entry_count == CNT_W'(ENTRIES))
    else $error("overflow without a full table, or with found");

  a_loc_needs_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && loc_out != '0 |-> found && !overflow)
    else $error("nonzero location without a hit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(loc_out)
      && $stable(entry_count) && $stable(overflow))
    else $error("result changed while stalled");

endmodule

bind key_location_table klt_checker u_klt_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .found       (rsp.found),
  .loc_out     (rsp.loc_out),
  .entry_count (rsp.entry_count),
  .overflow    (rsp.overflow)
);
